// ----- rtl/rcfd_pkg.sv -----
package rcfd_pkg;

   localparam int FRAME_BYTES_DEF  = 27;
   localparam int MAX_CHANNELS_DEF = 16;

   localparam logic [7:0] MARK_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_FLIP  = 8'h20;
   localparam logic [7:0] LEN_VALUE = 8'h19;
   localparam int         FLAGS_POS = 24;
   localparam int         PAYLOAD_POS = 2;

   localparam logic [2:0] REG_MODE     = 3'd0;
   localparam logic [2:0] REG_RAW_MIN  = 3'd1;
   localparam logic [2:0] REG_RAW_MAX  = 3'd2;
   localparam logic [2:0] REG_NORM_MIN = 3'd3;
   localparam logic [2:0] REG_NORM_MAX = 3'd4;
   localparam logic [2:0] REG_TIMEOUT  = 3'd5;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;
   localparam logic KIND_CHAN = 1'b0;
   localparam logic KIND_LOST = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CSUM,
      ST_CSUM_LAST,
      ST_FLAGS,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       kind;
      logic [3:0] channel_index;
      logic [15:0] channel_value;
      logic       failsafe;
      logic       lost_frame;
      logic       lost_comms;
      logic       last;
   } result_type;

endpackage

// ----- rtl/rcfd_ram.sv -----
module rcfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/rcfd_divider.sv -----
module rcfd_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [27:0] dividend,
   input  logic [10:0] divisor,
   output logic        done,
   output logic [27:0] quotient
);
   // restoring divider, one quotient bit per cycle, unsigned
   logic [27:0] quo_ff, quo_in;
   logic [11:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [11:0] trial;
   logic [11:0] sub;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[10:0], quo_ff[27]};
      sub     = trial - {1'b0, divisor};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 5'd27;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = sub;
            quo_in = {quo_ff[26:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[26:0], 1'b0};
         end
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ----- rtl/rc_frame_deframer_decoder.sv -----
// rc frame deframer / decoder
// req channel: one beat is either a received serial byte (func 0) or a
// timer tick (func 1). bytes are de-stuffed (0x7e marker, 0x7d escape) and
// written into a frame memory; a closing marker on a full frame starts a
// check and decode pass.
// rsp channel: one beat per channel value (8, 9 or 16 per good frame, last
// set on the final one) or a single loss-of-comms beat when the tick
// countdown runs out.
// a plain byte or tick is handled in the idle state alone. a closing
// marker starts a checksum sweep over the frame memory, then per
// channel 3 memory reads, one multiply and a serial divide; the
// divider sets the rate.
// the block takes no new beat while a decode or result is pending, so a
// stalled rsp side simply holds req_tready low; nothing is dropped.
// reset: no frame open, countdown expired, comms flagged lost, registers
// at their defaults. the frame memory is not cleared (never read unwritten).
// csr: apb style, register i at byte address 4*i, always ready.
module rc_frame_deframer_decoder #(
   parameter int FRAME_BYTES  = rcfd_pkg::FRAME_BYTES_DEF,
   parameter int MAX_CHANNELS = rcfd_pkg::MAX_CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // channel_index[3:0], channel_value[19:4], failsafe[20],
                                    // lost_frame[21], lost_comms[22], zero fill
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,   // last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(FRAME_BYTES);
   localparam int CW = $clog2(FRAME_BYTES + 1);

   // config registers
   logic [1:0]  mode_ff;
   logic [10:0] raw_min_ff, raw_max_ff;
   logic [15:0] norm_min_ff, norm_max_ff, timeout_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 2'd0;
         raw_min_ff  <= 11'd172;
         raw_max_ff  <= 11'd1811;
         norm_min_ff <= 16'd0;
         norm_max_ff <= 16'd1000;
         timeout_ff  <= 16'd100;
      end else if (csr_wr) begin
         case (csr_idx)
            rcfd_pkg::REG_MODE:     mode_ff     <= csr_pwdata[1:0];
            rcfd_pkg::REG_RAW_MIN:  raw_min_ff  <= csr_pwdata[10:0];
            rcfd_pkg::REG_RAW_MAX:  raw_max_ff  <= csr_pwdata[10:0];
            rcfd_pkg::REG_NORM_MIN: norm_min_ff <= csr_pwdata[15:0];
            rcfd_pkg::REG_NORM_MAX: norm_max_ff <= csr_pwdata[15:0];
            rcfd_pkg::REG_TIMEOUT:  timeout_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         rcfd_pkg::REG_MODE:     csr_prdata = {30'd0, mode_ff};
         rcfd_pkg::REG_RAW_MIN:  csr_prdata = {21'd0, raw_min_ff};
         rcfd_pkg::REG_RAW_MAX:  csr_prdata = {21'd0, raw_max_ff};
         rcfd_pkg::REG_NORM_MIN: csr_prdata = {16'd0, norm_min_ff};
         rcfd_pkg::REG_NORM_MAX: csr_prdata = {16'd0, norm_max_ff};
         rcfd_pkg::REG_TIMEOUT:  csr_prdata = {16'd0, timeout_ff};
         default:                csr_prdata = 32'd0;
      endcase
   end

   // control state
   rcfd_pkg::state_type state_ff, state_in;
   logic          in_frame_ff, in_frame_in;
   logic          esc_ff, esc_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   cd_ff, cd_in;
   logic          lost_ff, lost_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rcfd_pkg::result_type rsp_ff, rsp_in;

   // decode datapath
   logic [AW-1:0] ptr_ff, ptr_in;         // memory read pointer
   logic [8:0]    sum_ff, sum_in;         // end-around checksum
   logic          hdr_ok_ff, hdr_ok_in;
   logic [1:0]    flags_ff, flags_in;     // {failsafe, lost_frame}
   logic [3:0]    ch_ff, ch_in;
   logic [4:0]    nch_ff, nch_in;
   logic [7:0]    b0_ff, b0_in, b1_ff, b1_in;
   logic [10:0]   raw_ff, raw_in;
   logic [27:0]   prod_ff, prod_in;       // |(r-min)*(hi-lo)| < 2^28
   logic          neg_ff, neg_in;
   logic [15:0]   val_ff, val_in;

   // frame memory
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata, mem_rdata;

   rcfd_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   logic        div_start, div_done;
   logic [27:0] div_q;

   // the divider loads the product at the edge that ends the multiply step
   rcfd_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_in),
      .divisor  (raw_max_ff - raw_min_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   logic          req_fire;
   logic [7:0]    rx_b;
   logic [8:0]    sum_add;
   logic [7:0]    bitpos;
   logic [AW:0]   bpos;
   logic [23:0]   acc;
   logic [10:0]   clamp;
   logic signed [16:0] span;
   logic [16:0]   span_abs;
   logic [27:0]   q_signed;
   logic [5:0]    bitsh;

   assign req_tready = (state_ff == rcfd_pkg::ST_IDLE) && !rsp_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rx_b       = req_tdata ^ (esc_ff ? rcfd_pkg::ESC_FLIP : 8'h00);
   assign sum_add    = {1'b0, sum_ff[7:0]} + {1'b0, mem_rdata};
   // bit offset of channel ch: 11*ch, byte = payload + bit/8
   assign bitpos     = 8'(ch_ff) * 8'd11;
   assign bpos       = (AW+1)'(rcfd_pkg::PAYLOAD_POS) + (AW+1)'(bitpos[7:3]);
   assign acc        = {mem_rdata, b1_ff, b0_ff};
   assign bitsh      = {3'd0, bitpos[2:0]};
   assign span       = $signed({norm_max_ff[15], norm_max_ff})
                     - $signed({norm_min_ff[15], norm_min_ff});
   assign span_abs   = span[16] ? 17'(-span) : 17'(span);
   assign q_signed   = neg_ff ? 28'(-div_q) : div_q;

   always_comb begin
      if (raw_ff < raw_min_ff)      clamp = raw_min_ff;
      else if (raw_ff > raw_max_ff) clamp = raw_max_ff;
      else                          clamp = raw_ff;
   end

   always_comb begin
      state_in     = state_ff;
      in_frame_in  = in_frame_ff;
      esc_in       = esc_ff;
      count_in     = count_ff;
      cd_in        = cd_ff;
      lost_in      = lost_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      ptr_in       = ptr_ff;
      sum_in       = sum_ff;
      hdr_ok_in    = hdr_ok_ff;
      flags_in     = flags_ff;
      ch_in        = ch_ff;
      nch_in       = nch_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      raw_in       = raw_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      val_in       = val_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[AW-1:0];
      mem_wdata    = rx_b;
      mem_raddr    = ptr_ff;
      div_start    = 1'b0;

      case (state_ff)
         rcfd_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == rcfd_pkg::FUNC_TICK) begin
                  if (cd_ff != 16'd0) cd_in = cd_ff - 16'd1;
                  if ((cd_ff <= 16'd1) && !lost_ff) begin
                     lost_in      = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{kind: rcfd_pkg::KIND_LOST, channel_index: 4'd0,
                                      channel_value: 16'd0, failsafe: 1'b0,
                                      lost_frame: 1'b0, lost_comms: 1'b1, last: 1'b1};
                  end
               end else if (req_tdata == rcfd_pkg::MARK_BYTE) begin
                  if (in_frame_ff && count_ff == CW'(FRAME_BYTES)) begin
                     ptr_in    = '0;
                     sum_in    = '0;
                     hdr_ok_in = 1'b1;
                     state_in  = rcfd_pkg::ST_CSUM;
                  end
                  in_frame_in = 1'b1;
                  count_in    = '0;
                  esc_in      = 1'b0;
               end else if (in_frame_ff) begin
                  if (req_tdata == rcfd_pkg::ESC_BYTE) begin
                     esc_in = 1'b1;
                  end else begin
                     esc_in = 1'b0;
                     if (count_ff < CW'(FRAME_BYTES)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        in_frame_in = 1'b0;
                        count_in    = '0;
                     end
                  end
               end
            end
         end
         // sweep: address ptr issued, data of ptr-1 arrives
         rcfd_pkg::ST_CSUM: begin
            ptr_in = ptr_ff + AW'(1);
            if (ptr_ff != '0) begin
               if (ptr_ff == AW'(1) && mem_rdata != rcfd_pkg::LEN_VALUE) hdr_ok_in = 1'b0;
               if (ptr_ff == AW'(2) && mem_rdata != 8'h00) hdr_ok_in = 1'b0;
               sum_in = sum_add[8] ? {1'b0, sum_add[7:0] + 8'd1} : sum_add;
            end
            if (ptr_ff == AW'(FRAME_BYTES - 1)) state_in = rcfd_pkg::ST_CSUM_LAST;
         end
         rcfd_pkg::ST_CSUM_LAST: begin
            mem_raddr = AW'(rcfd_pkg::FLAGS_POS);
            state_in  = rcfd_pkg::ST_IDLE;
            if (hdr_ok_ff && (sum_ff[7:0] + mem_rdata) == 8'hFF) state_in = rcfd_pkg::ST_FLAGS;
         end
         rcfd_pkg::ST_FLAGS: begin
            flags_in = {mem_rdata[3], mem_rdata[2]};
            case (mode_ff)
               2'd0:    nch_in = 5'd8;
               2'd1:    nch_in = 5'd9;
               default: nch_in = 5'd16;
            endcase
            if (nch_in > 5'(MAX_CHANNELS)) nch_in = 5'(MAX_CHANNELS);
            cd_in    = timeout_ff;
            lost_in  = 1'b0;
            ch_in    = '0;
            state_in = rcfd_pkg::ST_RD0;
         end
         rcfd_pkg::ST_RD0: begin
            mem_raddr = bpos[AW-1:0];
            state_in  = rcfd_pkg::ST_RD1;
         end
         rcfd_pkg::ST_RD1: begin
            mem_raddr = bpos[AW-1:0] + AW'(1);
            b0_in     = mem_rdata;
            state_in  = rcfd_pkg::ST_RD2;
         end
         rcfd_pkg::ST_RD2: begin
            mem_raddr = bpos[AW-1:0] + AW'(2);
            b1_in     = (bpos + (AW+1)'(1) < (AW+1)'(FRAME_BYTES)) ? mem_rdata : 8'h00;
            state_in  = rcfd_pkg::ST_RD3;
         end
         rcfd_pkg::ST_RD3: begin
            raw_in   = 11'((bpos + (AW+1)'(2) < (AW+1)'(FRAME_BYTES) ? acc
                                : {8'h00, b1_ff, b0_ff}) >> bitsh);
            state_in = rcfd_pkg::ST_MUL;
         end
         rcfd_pkg::ST_MUL: begin
            prod_in   = 28'(11'(clamp - raw_min_ff)) * 28'(span_abs);
            neg_in    = span[16];
            div_start = 1'b1;
            state_in  = rcfd_pkg::ST_DIV;
            if (raw_max_ff <= raw_min_ff) begin
               val_in    = norm_min_ff;
               div_start = 1'b0;
               state_in  = rcfd_pkg::ST_EMIT;
            end
         end
         rcfd_pkg::ST_DIV: begin
            if (div_done) begin
               val_in   = q_signed[15:0] + norm_min_ff;
               state_in = rcfd_pkg::ST_EMIT;
            end
         end
         rcfd_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: rcfd_pkg::KIND_CHAN, channel_index: ch_ff,
                          channel_value: val_ff, failsafe: flags_ff[1],
                          lost_frame: flags_ff[0], lost_comms: 1'b0,
                          last: (5'(ch_ff) + 5'd1 == nch_ff)};
               ch_in    = ch_ff + 4'd1;
               state_in = (5'(ch_ff) + 5'd1 == nch_ff) ? rcfd_pkg::ST_IDLE
                                                       : rcfd_pkg::ST_RD0;
            end
         end
         default: state_in = rcfd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcfd_pkg::ST_IDLE;
         in_frame_ff  <= 1'b0;
         esc_ff       <= 1'b0;
         count_ff     <= '0;
         cd_ff        <= 16'd0;
         lost_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_frame_ff  <= in_frame_in;
         esc_ff       <= esc_in;
         count_ff     <= count_in;
         cd_ff        <= cd_in;
         lost_ff      <= lost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff    <= rsp_in;
      ptr_ff    <= ptr_in;
      sum_ff    <= sum_in;
      hdr_ok_ff <= hdr_ok_in;
      flags_ff  <= flags_in;
      ch_ff     <= ch_in;
      nch_ff    <= nch_in;
      b0_ff     <= b0_in;
      b1_ff     <= b1_in;
      raw_ff    <= raw_in;
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      val_ff    <= val_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.lost_comms, rsp_ff.lost_frame, rsp_ff.failsafe,
                        rsp_ff.channel_value, rsp_ff.channel_index};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

   // frame never grows past its memory
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(FRAME_BYTES))
      else $error("frame count overflow");
   // no input taken while a decode runs
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rcfd_pkg::ST_IDLE) |-> !req_tready)
      else $error("input taken during decode");
   // a loss beat only when the flag just got set
   a_lost_beat: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_ff.kind == rcfd_pkg::KIND_LOST) |-> lost_ff)
      else $error("loss beat without flag");
   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("result changed under stall");
endmodule

// ----- tb/rc_frame_deframer_decoder_test.sv -----
`timescale 1ns / 1ps

module rc_frame_deframer_decoder_test;
   import rcfd_pkg::*;

   localparam int NBYTES     = FRAME_BYTES_DEF;
   localparam int STALL_MAX  = 20000;  // cycles with no beat on either side
   localparam int SETTLE     = 100;    // covers a checksum sweep that yields nothing
   localparam int HOLD_LONG  = 1500;

   // directed row kinds
   typedef enum int {
      D_BYTE, D_TICK, D_GOOD, D_BADLEN, D_BADTYPE, D_BADSUM, D_OVERRUN, D_SHORT
   } row_kind_type;

   typedef struct {
      row_kind_type op;
      logic [7:0]   arg;
      int           want;   // result count typed in, -1 means predictor only
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // rx_byte
   logic        req_tuser = 1'b0;    // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // channel_index, channel_value, failsafe,
                                     // lost_frame, lost_comms, zero fill
   logic        rsp_tuser;           // kind
   logic        rsp_tlast;           // last
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = 5'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rc_frame_deframer_decoder uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the block's registers
   logic [1:0]         chan_mode;
   logic [10:0]        raw_lo, raw_hi;
   logic signed [15:0] norm_lo, norm_hi;
   logic [15:0]        timeout_load;

   // shadow copy of the deframer state
   bit          framing, escaping;
   int          stored;
   logic [7:0]  frame_mem [NBYTES];
   logic [15:0] countdown;
   bit          comms_down;

   result_type channel_q [$];   // decoded beats still owed by the block

   int errors = 0;
   int send_pct = 0;     // chance in a hundred that the sender idles before a beat
   int stall_pct = 0;    // same for the receiver
   bit hold_req = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   // ---------------------------------------------------------------- predictor
   function automatic logic [10:0] raw_channel(input int ch);
      int bitpos, pos;
      logic [23:0] acc;
      bitpos = ch * 11;
      pos = PAYLOAD_POS + bitpos / 8;
      acc = '0;
      for (int k = 0; k < 3; k++)
         if (pos + k < NBYTES) acc |= 24'(frame_mem[pos + k]) << (8 * k);
      return 11'(acc >> (bitpos % 8));
   endfunction

   function automatic logic [15:0] scaled(input logic [10:0] r);
      longint lo, hi, rl, rh, rv, q;
      lo = norm_lo;
      hi = norm_hi;
      rl = raw_lo;
      rh = raw_hi;
      if (rh <= rl) return 16'(lo);
      rv = r;
      if (rv < rl) rv = rl;
      if (rv > rh) rv = rh;
      // signed division truncates toward zero
      q = ((rv - rl) * (hi - lo)) / (rh - rl);
      return 16'(q + lo);
   endfunction

   function automatic bit sum_holds();
      int s;
      s = 0;
      for (int i = 0; i < NBYTES - 1; i++) begin
         s += frame_mem[i];
         if (s > 255) s = (s & 255) + 1;
      end
      return ((s + frame_mem[NBYTES - 1]) & 255) == 255;
   endfunction

   function automatic int decode_frame();
      int n;
      result_type r;
      if (stored != NBYTES) return 0;
      if (frame_mem[0] != LEN_VALUE || frame_mem[1] != 8'h00) return 0;
      if (!sum_holds()) return 0;
      n = (chan_mode == 2'd0) ? 8 : (chan_mode == 2'd1) ? 9 : 16;
      if (n > MAX_CHANNELS_DEF) n = MAX_CHANNELS_DEF;
      for (int i = 0; i < n; i++) begin
         r.kind          = KIND_CHAN;
         r.channel_index = 4'(i);
         r.channel_value = scaled(raw_channel(i));
         r.failsafe      = frame_mem[FLAGS_POS][3];
         r.lost_frame    = frame_mem[FLAGS_POS][2];
         r.lost_comms    = 1'b0;
         r.last          = (i == n - 1);
         channel_q.push_back(r);
      end
      countdown  = timeout_load;
      comms_down = 0;
      return n;
   endfunction

   // advance the shadow state by one accepted beat, queue what it produces
   function automatic int deframe_step(input logic func, input logic [7:0] b);
      result_type r;
      if (func == FUNC_TICK) begin
         if (countdown != 0) countdown--;
         if (countdown == 0 && !comms_down) begin
            comms_down = 1;
            r = '{kind: KIND_LOST, channel_index: 4'd0, channel_value: 16'd0,
                  failsafe: 1'b0, lost_frame: 1'b0, lost_comms: 1'b1, last: 1'b1};
            channel_q.push_back(r);
            return 1;
         end
         return 0;
      end
      if (b == MARK_BYTE) begin
         int n;
         n = (framing && stored > 0) ? decode_frame() : 0;
         framing = 1;
         stored = 0;
         escaping = 0;
         return n;
      end
      if (!framing) return 0;
      if (b == ESC_BYTE) begin
         escaping = 1;
         return 0;
      end
      if (escaping) begin
         b ^= ESC_FLIP;
         escaping = 0;
      end
      if (stored < NBYTES) begin
         frame_mem[stored] = b;
         stored++;
      end else begin
         // overrun: frame dropped, wait for the next marker
         framing = 0;
         stored = 0;
      end
      return 0;
   endfunction

   // ---------------------------------------------------------------- receiver
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (channel_q.size() == 0) begin
               report($sformatf("unexpected beat tdata=%h", rsp_tdata));
            end else begin
               result_type e;
               e = channel_q.pop_front();
               if (rsp_tuser !== e.kind)
                  report($sformatf("kind %b, want %b", rsp_tuser, e.kind));
               if (rsp_tdata[3:0] !== e.channel_index)
                  report($sformatf("index %0d, want %0d", rsp_tdata[3:0],
                                   e.channel_index));
               if (rsp_tdata[19:4] !== e.channel_value)
                  report($sformatf("ch %0d value %0d, want %0d", e.channel_index,
                                   $signed(rsp_tdata[19:4]),
                                   $signed(e.channel_value)));
               if (rsp_tdata[20] !== e.failsafe)
                  report($sformatf("failsafe %b, want %b", rsp_tdata[20],
                                   e.failsafe));
               if (rsp_tdata[21] !== e.lost_frame)
                  report($sformatf("lost_frame %b, want %b", rsp_tdata[21],
                                   e.lost_frame));
               if (rsp_tdata[22] !== e.lost_comms)
                  report($sformatf("lost_comms %b, want %b", rsp_tdata[22],
                                   e.lost_comms));
               if (rsp_tlast !== e.last)
                  report($sformatf("last %b, want %b", rsp_tlast, e.last));
            end
         end
         // long hold-off so the block backs up into the req side
         if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_LONG;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog: no beat on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sender
   task automatic send_beat(input logic func, input logic [7:0] b, output int n);
      if (send_pct > 0 && $urandom_range(99) < send_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      n = deframe_step(func, b);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (channel_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_MODE:     chan_mode    = val[1:0];
         REG_RAW_MIN:  raw_lo       = val[10:0];
         REG_RAW_MAX:  raw_hi       = val[10:0];
         REG_NORM_MIN: norm_lo      = val[15:0];
         REG_NORM_MAX: norm_hi      = val[15:0];
         REG_TIMEOUT:  timeout_load = val[15:0];
         default: ;
      endcase
   endtask

   task automatic setup(input logic [1:0] m, input logic [10:0] rl, rh,
                        input logic [15:0] nl, nh, tmo);
      drain();
      csr_write(REG_MODE, 32'(m));
      csr_write(REG_RAW_MIN, 32'(rl));
      csr_write(REG_RAW_MAX, 32'(rh));
      csr_write(REG_NORM_MIN, 32'(nl));
      csr_write(REG_NORM_MAX, 32'(nh));
      csr_write(REG_TIMEOUT, 32'(tmo));
   endtask

   // build one frame (good or broken), stuff it and send it between markers;
   // arg 00 = all channels zero, ff = all channels full scale, else random
   task automatic send_frame(input row_kind_type op, input logic [7:0] arg,
                             output int nres, inout int sent);
      logic [7:0]  f [NBYTES + 1];
      logic [10:0] ch;
      int s, len, n;
      nres = 0;
      for (int i = 0; i <= NBYTES; i++) f[i] = 8'h00;
      f[0] = LEN_VALUE;
      for (int c = 0; c < 16; c++) begin
         case (arg)
            8'h00: ch = 11'd0;
            8'hFF: ch = 11'h7FF;
            default: begin
               case ($urandom_range(4))
                  0: ch = raw_lo;
                  1: ch = raw_hi;
                  2: ch = $urandom_range(1) ? 11'h7FF : 11'd0;
                  default: ch = 11'($urandom);
               endcase
            end
         endcase
         for (int k = 0; k < 11; k++) begin
            s = c * 11 + k;
            f[PAYLOAD_POS + s / 8][s % 8] = ch[k];
         end
      end
      f[FLAGS_POS] = (arg == 8'h00) ? 8'h00 : (arg == 8'hFF) ? 8'h0C : 8'($urandom);
      // byte 25 often forced onto a marker or escape value to exercise stuffing
      f[25] = ($urandom_range(2) == 0) ? ($urandom_range(1) ? MARK_BYTE : ESC_BYTE)
                                       : 8'($urandom);
      if (op == D_BADLEN) f[0] = LEN_VALUE ^ 8'($urandom_range(1, 255));
      if (op == D_BADTYPE) f[1] = 8'($urandom_range(1, 255));
      s = 0;
      for (int i = 0; i < NBYTES - 1; i++) begin
         s += f[i];
         if (s > 255) s = (s & 255) + 1;
      end
      f[NBYTES - 1] = 8'(255 - s);
      if (op == D_BADSUM) f[NBYTES - 1] ^= 8'($urandom_range(1, 255));
      len = (op == D_OVERRUN) ? NBYTES + 1 : (op == D_SHORT) ? NBYTES - 1 : NBYTES;
      send_beat(FUNC_BYTE, MARK_BYTE, n);
      nres += n;
      for (int i = 0; i < len; i++) begin
         if (f[i] == MARK_BYTE || f[i] == ESC_BYTE) begin
            send_beat(FUNC_BYTE, ESC_BYTE, n);
            send_beat(FUNC_BYTE, f[i] ^ ESC_FLIP, n);
            sent += 2;
         end else begin
            send_beat(FUNC_BYTE, f[i], n);
            sent++;
         end
      end
      send_beat(FUNC_BYTE, MARK_BYTE, n);
      nres += n;
      sent += 2;
   endtask

   // ---------------------------------------------------------------- directed
   row_type rows [] = '{
      '{D_TICK,    8'h00, 0},   // comms already lost after reset: silent
      '{D_BYTE,    8'h55, 0},   // outside a frame: ignored
      '{D_BYTE,    ESC_BYTE, 0},
      '{D_BYTE,    MARK_BYTE, 0},
      '{D_BYTE,    ESC_BYTE, 0},  // double escape then 0x5e stores a marker value
      '{D_BYTE,    ESC_BYTE, 0},
      '{D_BYTE,    8'h5E, 0},
      '{D_BYTE,    MARK_BYTE, 0},  // one-byte frame dropped
      '{D_GOOD,    8'h00, 8},      // raw zero clamps to norm_min
      '{D_TICK,    8'hFF, 0},
      '{D_TICK,    8'h00, 1},      // countdown of two runs out
      '{D_TICK,    8'h00, 0},
      '{D_GOOD,    8'hFF, 8},      // full scale, failsafe and lost_frame set
      '{D_BADLEN,  8'h5A, 0},
      '{D_BADTYPE, 8'h5A, 0},
      '{D_BADSUM,  8'h5A, 0},
      '{D_OVERRUN, 8'h5A, 0},
      '{D_SHORT,   8'h5A, 0},
      '{D_TICK,    8'h00, 0},
      '{D_TICK,    8'h00, 1},
      '{D_GOOD,    8'h5A, -1}
   };

   initial begin
      int n, sent, goal;
      bit paused;
      result_type lost_beat;
      lost_beat = '{kind: KIND_LOST, channel_index: 4'd0, channel_value: 16'd0,
                    failsafe: 1'b0, lost_frame: 1'b0, lost_comms: 1'b1, last: 1'b1};

      // reset state of the shadow copy
      chan_mode = 2'd0;  raw_lo = 11'd172;  raw_hi = 11'd1811;
      norm_lo = 16'sd0;  norm_hi = 16'sd1000;  timeout_load = 16'd100;
      framing = 0;  escaping = 0;  stored = 0;
      countdown = 16'd0;  comms_down = 1;
      paused = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(REG_TIMEOUT, 32'd2);
      sent = 0;
      foreach (rows[i]) begin
         if (rows[i].op == D_BYTE || rows[i].op == D_TICK)
            send_beat(rows[i].op == D_TICK ? FUNC_TICK : FUNC_BYTE, rows[i].arg, n);
         else
            send_frame(rows[i].op, rows[i].arg, n, sent);
         if (rows[i].want >= 0 && n != rows[i].want)
            report($sformatf("row %0d gives %0d beats, want %0d", i, n, rows[i].want));
         if (rows[i].op == D_TICK && rows[i].want == 1 && n == 1 &&
             channel_q[$] != lost_beat)
            report($sformatf("row %0d loss-of-comms beat wrong", i));
      end

      // ------------------------------------------------------------ random
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: setup(2'd0, 11'd172, 11'd1811, 16'd0, 16'd1000, 16'd1);
            1: setup(2'd1, 11'd0, 11'h7FF, 16'h8000, 16'h7FFF, 16'd3);
            2: setup(2'd2, 11'($urandom), 11'($urandom), 16'($urandom), 16'($urandom),
                     16'hFFFF);
            default: setup(2'd3, 11'd1000, 11'd1000, 16'h7FFF, 16'h8000, 16'd5);
         endcase
         send_pct  = (phase == 1) ? 82 : (phase == 3) ? 33 : 0;
         stall_pct = (phase == 2) ? 82 : (phase == 3) ? 33 : 0;
         if (phase == 0) hold_req = 1;   // block fills and stalls req side
         goal = sent + 35;
         while (sent < goal) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: send_frame(D_GOOD, 8'h5A, n, sent);
               6: send_frame(row_kind_type'($urandom_range(D_BADLEN, D_SHORT)), 8'h5A,
                             n, sent);
               7, 8: begin
                  repeat ($urandom_range(1, 6)) begin
                     send_beat(FUNC_TICK, 8'($urandom), n);
                     sent++;
                  end
               end
               default: begin
                  repeat ($urandom_range(1, 4)) begin
                     send_beat(FUNC_BYTE, $urandom_range(3) == 0 ? MARK_BYTE
                                                                 : 8'($urandom), n);
                     sent++;
                  end
               end
            endcase
            // one pause until the block has handed over everything owed
            if (phase == 1 && !paused) begin
               paused = 1;
               req_tvalid <= 1'b0;
               while (channel_q.size() != 0) @(posedge clock);
            end
         end
      end

      drain();
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
